// File: rtl/galois_field_arithmetic_unit_macros.svh
// Assertion macros for the Galois field arithmetic unit.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef GALOIS_FIELD_ARITHMETIC_UNIT_MACROS_SVH
`define GALOIS_FIELD_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GFAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gfau_pkg.sv
// Shared types, constants and the microcode ROM for the Galois field arithmetic unit.
// No dependencies; used by gfau_mul and galois_field_arithmetic_unit.
`timescale 1ns / 1ps

package gfau_pkg;

  // Widths of the request and response fields.
  localparam int DATA_W = 8;
  localparam int OP_W   = 2;

  // Default field size and multiplier digit size (bits handled per cycle).
  localparam int FIELD_BITS_DEF = 8;
  localparam int MUL_DIGIT      = 8;

  // Reset value of the reduction polynomial register.
  localparam logic [DATA_W-1:0] POLY_RESET = 8'h1D;

  // Opcodes.
  localparam logic [OP_W-1:0] OPC_MUL = 2'd0;
  localparam logic [OP_W-1:0] OPC_POW = 2'd1;
  localparam logic [OP_W-1:0] OPC_INV = 2'd2;

  // Request and response payloads.
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              error;
  } out_rsp_t;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    U_NOP,
    U_LOAD,
    U_RES_ZERO,
    U_RES_UT,
    U_RES_ERR,
    U_EMIT,
    U_MUL_AB,
    U_MUL_ACC_BASE,
    U_MUL_BASE_BASE,
    U_WB_ACC,
    U_WB_BASE,
    U_EXP_SHIFT,
    U_DEG_SEARCH,
    U_DIV_INIT,
    U_DIV_STEP,
    U_SWAP
  } uop_t;

  // Jump conditions: when true the sequencer goes to the target, else to the next step.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_OP_MUL,
    C_OP_POW,
    C_OP_INV,
    C_MUL_BUSY,
    C_EXP_ZERO,
    C_EXP_EVEN,
    C_EXP_LAST,
    C_VR_ZERO,
    C_VR_TOP_CLEAR,
    C_DQ_MORE,
    C_OUT_FULL
  } cond_t;

  localparam int PC_W = 5;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Program addresses that are jumped to or watched from outside the ROM.
  localparam logic [PC_W-1:0] A_EMIT     = 5'd0;
  localparam logic [PC_W-1:0] A_IDLE     = 5'd1;
  localparam logic [PC_W-1:0] A_DISPATCH = 5'd2;
  localparam logic [PC_W-1:0] A_RSVD     = 5'd5;
  localparam logic [PC_W-1:0] A_MUL      = 5'd6;
  localparam logic [PC_W-1:0] A_POW      = 5'd9;
  localparam logic [PC_W-1:0] A_POW_BIT  = 5'd10;
  localparam logic [PC_W-1:0] A_POW_SHR  = 5'd13;
  localparam logic [PC_W-1:0] A_INV      = 5'd17;
  localparam logic [PC_W-1:0] A_INV_LOOP = 5'd18;
  localparam logic [PC_W-1:0] A_DEG      = 5'd19;
  localparam logic [PC_W-1:0] A_DIV      = 5'd21;
  localparam logic [PC_W-1:0] A_INV_DONE = 5'd23;
  localparam logic [PC_W-1:0] A_INV_ERR  = 5'd24;

  // Microcode ROM. The emit step sits at address zero so that falling through it
  // lands on the idle step without a spare cycle.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{uop: U_NOP, cond: C_ALWAYS, target: A_IDLE};
    unique case (pc)
      // Hand the finished result to the output register, then fall into idle.
      A_EMIT:          w = '{uop: U_EMIT,          cond: C_OUT_FULL,     target: A_EMIT};
      A_IDLE:          w = '{uop: U_LOAD,          cond: C_NO_REQ,       target: A_IDLE};
      // Opcode dispatch; the reserved opcode falls through to a zero result.
      A_DISPATCH:      w = '{uop: U_NOP,           cond: C_OP_MUL,       target: A_MUL};
      A_DISPATCH + 1:  w = '{uop: U_NOP,           cond: C_OP_POW,       target: A_POW};
      A_DISPATCH + 2:  w = '{uop: U_NOP,           cond: C_OP_INV,       target: A_INV};
      A_RSVD:          w = '{uop: U_RES_ZERO,      cond: C_ALWAYS,       target: A_EMIT};
      // Single field product.
      A_MUL:           w = '{uop: U_MUL_AB,        cond: C_NEVER,        target: A_EMIT};
      A_MUL + 1:       w = '{uop: U_WB_ACC,        cond: C_MUL_BUSY,     target: A_MUL + 1};
      A_MUL + 2:       w = '{uop: U_NOP,           cond: C_ALWAYS,       target: A_EMIT};
      // Square and multiply, LSB first.
      A_POW:           w = '{uop: U_NOP,           cond: C_EXP_ZERO,     target: A_EMIT};
      A_POW_BIT:       w = '{uop: U_NOP,           cond: C_EXP_EVEN,     target: A_POW_SHR};
      A_POW_BIT + 1:   w = '{uop: U_MUL_ACC_BASE,  cond: C_NEVER,        target: A_EMIT};
      A_POW_BIT + 2:   w = '{uop: U_WB_ACC,        cond: C_MUL_BUSY,     target: A_POW_BIT + 2};
      A_POW_SHR:       w = '{uop: U_EXP_SHIFT,     cond: C_EXP_LAST,     target: A_EMIT};
      A_POW_SHR + 1:   w = '{uop: U_MUL_BASE_BASE, cond: C_NEVER,        target: A_EMIT};
      A_POW_SHR + 2:   w = '{uop: U_WB_BASE,       cond: C_MUL_BUSY,     target: A_POW_SHR + 2};
      A_POW_SHR + 3:   w = '{uop: U_NOP,           cond: C_ALWAYS,       target: A_POW_BIT};
      // Extended Euclid: degree search, bit-serial long division, swap.
      A_INV:           w = '{uop: U_NOP,           cond: C_VR_ZERO,      target: A_INV_ERR};
      A_INV_LOOP:      w = '{uop: U_NOP,           cond: C_VR_ZERO,      target: A_INV_DONE};
      A_DEG:           w = '{uop: U_DEG_SEARCH,    cond: C_VR_TOP_CLEAR, target: A_DEG};
      A_DEG + 1:       w = '{uop: U_DIV_INIT,      cond: C_NEVER,        target: A_EMIT};
      A_DIV:           w = '{uop: U_DIV_STEP,      cond: C_DQ_MORE,      target: A_DIV};
      A_DIV + 1:       w = '{uop: U_SWAP,          cond: C_ALWAYS,       target: A_INV_LOOP};
      A_INV_DONE:      w = '{uop: U_RES_UT,        cond: C_ALWAYS,       target: A_EMIT};
      A_INV_ERR:       w = '{uop: U_RES_ERR,       cond: C_ALWAYS,       target: A_EMIT};
      default:         w = '{uop: U_NOP,           cond: C_ALWAYS,       target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/gfau_mul.sv
// Digit-serial GF(2^n) multiplier: MSB-first shift, reduce and add, one digit per cycle.
// Depends on gfau_pkg for the default field and digit sizes.
`timescale 1ns / 1ps

module gfau_mul #(
  parameter int FIELD_BITS = gfau_pkg::FIELD_BITS_DEF,
  parameter int DIGIT      = gfau_pkg::MUL_DIGIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [FIELD_BITS-1:0] op_a,
  input  logic [FIELD_BITS-1:0] op_b,
  input  logic [FIELD_BITS-1:0] poly,
  output logic                  busy,
  output logic [FIELD_BITS-1:0] product
);

  localparam int ND = (FIELD_BITS + DIGIT - 1) / DIGIT;
  localparam int BW = ND * DIGIT;
  localparam int CW = $clog2(ND + 1);

  logic [FIELD_BITS-1:0] a_r;
  logic [BW-1:0]         b_r;
  logic [FIELD_BITS-1:0] p_r;
  logic [CW-1:0]         cnt_r;
  logic [FIELD_BITS-1:0] p_nxt;

  // One digit of the product: shift left with reduction, then add the multiplicand.
  // The multiplier is zero-padded on top, so leading steps leave the sum at zero.
  always_comb begin
    logic [FIELD_BITS-1:0] p;
    logic                  top;
    p = p_r;
    for (int j = 0; j < DIGIT; j++) begin
      top = p[FIELD_BITS-1];
      p   = {p[FIELD_BITS-2:0], 1'b0} ^ (top ? poly : '0);
      if (b_r[BW-1-j]) begin
        p = p ^ a_r;
      end
    end
    p_nxt = p;
  end

  // Digit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(ND);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // Operand and partial product registers.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= BW'(op_b);
      p_r <= '0;
    end else if (cnt_r != '0) begin
      p_r <= p_nxt;
      b_r <= b_r << DIGIT;
    end
  end

  assign busy    = (cnt_r != '0);
  assign product = p_r;

endmodule

// File: rtl/galois_field_arithmetic_unit.sv
// Top level of the Galois field arithmetic unit: microcode sequencer and datapath.
// Depends on gfau_pkg, gfau_mul and galois_field_arithmetic_unit_macros.svh.
`timescale 1ns / 1ps

// GF(2^FIELD_BITS) multiply, power and inverse under a programmable reduction
// polynomial (leading term implied). One request at a time is processed by a
// microcoded sequencer; the result sits in an output register, so a new request
// is taken while the previous result still waits. Field products go through the
// shared digit-serial multiplier, a power runs square and multiply over the
// exponent bits, and an inverse runs Euclid rounds of a degree search and a
// bit-serial long division. The reserved opcode gives a zero result; the
// inverse of zero gives zero with error set.
module galois_field_arithmetic_unit #(
  parameter int FIELD_BITS = gfau_pkg::FIELD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  gfau_pkg::in_req_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output gfau_pkg::out_rsp_t                    out_data,
  input  logic                                  cfg_wr_en,
  input  logic [gfau_pkg::DATA_W-1:0]           cfg_wr_data
);

  `include "galois_field_arithmetic_unit_macros.svh"

  localparam int W   = FIELD_BITS;
  localparam int W1  = FIELD_BITS + 1;
  localparam int DGW = $clog2(W1);
  localparam int DW  = gfau_pkg::DATA_W;
  localparam int PW  = gfau_pkg::PC_W;

  // Control and configuration state.
  logic [PW-1:0]          pc_r;
  logic [PW-1:0]          pc_nxt;
  logic                   out_valid_r;
  gfau_pkg::out_rsp_t     out_data_r;
  logic [DW-1:0]          poly_r;

  // Datapath registers.
  logic [gfau_pkg::OP_W-1:0] op_r;
  logic                      err_r;
  logic [W-1:0]              acc_r;
  logic [W-1:0]              base_r;
  logic [W-1:0]              exp_r;
  logic [W1-1:0]             ur_r;
  logic [W1-1:0]             vr_r;
  logic [W1-1:0]             ut_r;
  logic [W1-1:0]             vt_r;
  logic [DGW-1:0]            du_r;
  logic [DGW-1:0]            dv_r;
  logic [DGW-1:0]            dq_r;

  gfau_pkg::ucode_t ucw;
  logic             cond_true;
  logic             in_accept;
  logic             out_full;
  logic [W-1:0]     poly_f;
  logic [W-1:0]     a_f;
  logic [W-1:0]     b_f;
  logic [DGW-1:0]   shamt;
  logic             mul_start;
  logic [W-1:0]     mul_a;
  logic [W-1:0]     mul_b;
  logic             mul_busy;
  logic [W-1:0]     mul_prod;

  // Fit the 8-bit port values to the field width.
  assign poly_f = W'(poly_r);
  assign a_f    = W'(in_data.operand_a);
  assign b_f    = W'(in_data.operand_b);

  // Handshake status.
  assign in_stall  = (pc_r != gfau_pkg::A_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_full  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control word fetch.
  assign ucw = gfau_pkg::ucode_rom(pc_r);

  // Jump condition evaluation and next step.
  always_comb begin
    unique case (ucw.cond)
      gfau_pkg::C_NEVER:        cond_true = 1'b0;
      gfau_pkg::C_ALWAYS:       cond_true = 1'b1;
      gfau_pkg::C_NO_REQ:       cond_true = !in_valid;
      gfau_pkg::C_OP_MUL:       cond_true = (op_r == gfau_pkg::OPC_MUL);
      gfau_pkg::C_OP_POW:       cond_true = (op_r == gfau_pkg::OPC_POW);
      gfau_pkg::C_OP_INV:       cond_true = (op_r == gfau_pkg::OPC_INV);
      gfau_pkg::C_MUL_BUSY:     cond_true = mul_busy;
      gfau_pkg::C_EXP_ZERO:     cond_true = (exp_r == '0);
      gfau_pkg::C_EXP_EVEN:     cond_true = !exp_r[0];
      gfau_pkg::C_EXP_LAST:     cond_true = ((exp_r >> 1) == '0);
      gfau_pkg::C_VR_ZERO:      cond_true = (vr_r == '0);
      gfau_pkg::C_VR_TOP_CLEAR: cond_true = !vr_r[dv_r];
      gfau_pkg::C_DQ_MORE:      cond_true = (dq_r != dv_r);
      gfau_pkg::C_OUT_FULL:     cond_true = out_full;
      default:                  cond_true = 1'b0;
    endcase
    pc_nxt = cond_true ? ucw.target : pc_r + PW'(1);
  end

  // Step counter, output valid and polynomial register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= gfau_pkg::A_IDLE;
      out_valid_r <= 1'b0;
      poly_r      <= gfau_pkg::POLY_RESET;
    end else begin
      pc_r <= pc_nxt;
      if (ucw.uop == gfau_pkg::U_EMIT && !out_full) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        poly_r <= cfg_wr_data;
      end
    end
  end

  // Result register load.
  always_ff @(posedge clk) begin
    if (ucw.uop == gfau_pkg::U_EMIT && !out_full) begin
      out_data_r.result <= DW'(acc_r);
      out_data_r.error  <= err_r;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = base_r;
    mul_b     = exp_r;
    case (ucw.uop)
      gfau_pkg::U_MUL_AB: begin
        mul_start = 1'b1;
      end
      gfau_pkg::U_MUL_ACC_BASE: begin
        mul_start = 1'b1;
        mul_a     = acc_r;
        mul_b     = base_r;
      end
      gfau_pkg::U_MUL_BASE_BASE: begin
        mul_start = 1'b1;
        mul_b     = base_r;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  gfau_mul #(
    .FIELD_BITS (FIELD_BITS),
    .DIGIT      (gfau_pkg::MUL_DIGIT)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .poly    (poly_f),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  // Alignment of the divisor under the current dividend bit.
  assign shamt = dq_r - dv_r;

  // Datapath micro-operations.
  always_ff @(posedge clk) begin
    unique case (ucw.uop)
      gfau_pkg::U_LOAD: begin
        if (in_accept) begin
          op_r   <= in_data.opcode;
          err_r  <= 1'b0;
          acc_r  <= W'(1);
          base_r <= a_f;
          exp_r  <= b_f;
          ur_r   <= {1'b1, poly_f};
          vr_r   <= {1'b0, a_f};
          ut_r   <= '0;
          vt_r   <= W1'(1);
          du_r   <= DGW'(W);
          dv_r   <= DGW'(W - 1);
        end
      end
      gfau_pkg::U_RES_ZERO: begin
        acc_r <= '0;
      end
      gfau_pkg::U_RES_UT: begin
        acc_r <= ut_r[W-1:0];
      end
      gfau_pkg::U_RES_ERR: begin
        acc_r <= '0;
        err_r <= 1'b1;
      end
      gfau_pkg::U_WB_ACC: begin
        if (!mul_busy) begin
          acc_r <= mul_prod;
        end
      end
      gfau_pkg::U_WB_BASE: begin
        if (!mul_busy) begin
          base_r <= mul_prod;
        end
      end
      gfau_pkg::U_EXP_SHIFT: begin
        exp_r <= exp_r >> 1;
      end
      gfau_pkg::U_DEG_SEARCH: begin
        if (!vr_r[dv_r]) begin
          dv_r <= dv_r - DGW'(1);
        end
      end
      gfau_pkg::U_DIV_INIT: begin
        dq_r <= du_r;
      end
      gfau_pkg::U_DIV_STEP: begin
        // One quotient bit: cancel the dividend's bit and track the Bezout term.
        if (ur_r[dq_r]) begin
          ur_r <= ur_r ^ (vr_r << shamt);
          ut_r <= ut_r ^ (vt_r << shamt);
        end
        dq_r <= dq_r - DGW'(1);
      end
      gfau_pkg::U_SWAP: begin
        // The remainder becomes the new divisor; its degree is below the old one.
        ur_r <= vr_r;
        vr_r <= ur_r;
        ut_r <= vt_r;
        vt_r <= ut_r;
        du_r <= dv_r;
        dv_r <= (dv_r == '0) ? '0 : dv_r - DGW'(1);
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer and datapath.
  `GFAU_ASSERT_NEXT(a_accept_dispatch, in_accept, pc_r == gfau_pkg::A_DISPATCH, "accepted request did not reach dispatch")
  `GFAU_ASSERT_SAME(a_mul_no_restart, mul_start, !mul_busy, "multiplier restarted while busy")
  `GFAU_ASSERT_SAME(a_err_only_inv, ucw.uop == gfau_pkg::U_EMIT && err_r, op_r == gfau_pkg::OPC_INV && acc_r == '0, "error flag without inverse of zero")
  `GFAU_ASSERT_SAME(a_out_from_emit, $rose(out_valid_r), $past(ucw.uop == gfau_pkg::U_EMIT), "output valid rose outside emit step")

endmodule

// File: test/galois_field_arithmetic_unit_tb.sv
// Self-checking testbench for galois_field_arithmetic_unit: multiply, power and inverse
// under several reduction polynomials, checked against a GF(2^8) model kept in this file.
// Depends on gfau_pkg and the galois_field_arithmetic_unit RTL.
`timescale 1ns / 1ps

module galois_field_arithmetic_unit_tb;
  import gfau_pkg::*;

  localparam int FIELD_BITS = 8;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int NUM_PHASES = 7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int BURST_LEN = 25;
  localparam int MAX_REPORTS = 50;
  // The opcode that the package leaves unused.
  localparam logic [OP_W-1:0] OPC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;

  // Shared testbench state.
  in_req_t req_q[$];
  out_rsp_t expected_rsp_q[$];
  logic [DATA_W-1:0] poly_model = POLY_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic holdoff_trigger = 1'b0;
  logic holdoff_seen = 1'b0;
  int holdoff_cnt = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  out_rsp_t want_rsp;

  galois_field_arithmetic_unit #(
    .FIELD_BITS(FIELD_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Field product: MSB-first shift and add, reducing whenever a set bit shifts out.
  function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] poly);
    logic [7:0] p;
    logic top;
    p = '0;
    for (int i = 7; i >= 0; i--) begin
      top = p[7];
      p = p << 1;
      if (top) p ^= poly;
      if (b[i]) p ^= a;
    end
    return p;
  endfunction

  // Square and multiply, LSB of the exponent first; a zero exponent gives 1.
  function automatic logic [7:0] field_power(input logic [7:0] base, input logic [7:0] e,
                                             input logic [7:0] poly);
    logic [7:0] p;
    logic [7:0] b;
    logic [7:0] x;
    p = 8'd1;
    b = base;
    x = e;
    while (x != 0) begin
      if (x[0]) p = field_product(p, b, poly);
      x = x >> 1;
      if (x != 0) b = field_product(b, b, poly);
    end
    return p;
  endfunction

  function automatic int poly_degree(input logic [8:0] v);
    int d;
    d = -1;
    for (int i = 0; i < 9; i++)
      if (v[i]) d = i;
    return d;
  endfunction

  // Carry-less product; only the low bits matter for the coefficient kept.
  function automatic logic [15:0] carryless_product(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] p;
    p = '0;
    for (int i = 0; i < 16; i++)
      if (b[i]) p ^= a << i;
    return p;
  endfunction

  // Extended Euclid against the full field polynomial; a must be nonzero.
  function automatic logic [7:0] field_inverse(input logic [7:0] a, input logic [7:0] poly);
    logic [8:0] old_r;
    logic [8:0] r;
    logic [8:0] tmp_r;
    logic [15:0] old_t;
    logic [15:0] t;
    logic [15:0] tmp_t;
    logic [15:0] quo;
    int dr;
    old_r = {1'b1, poly};
    r = {1'b0, a};
    old_t = '0;
    t = 16'd1;
    while (r != 0) begin
      dr = poly_degree(r);
      quo = '0;
      for (int bit_i = poly_degree(old_r); bit_i >= dr; bit_i--) begin
        if (old_r[bit_i]) begin
          old_r ^= r << (bit_i - dr);
          quo[bit_i - dr] = 1'b1;
        end
      end
      old_t ^= carryless_product(quo, t);
      tmp_r = old_r; old_r = r; r = tmp_r;
      tmp_t = old_t; old_t = t; t = tmp_t;
    end
    return old_t[7:0];
  endfunction

  // Expected response for one request under the current polynomial.
  function automatic out_rsp_t gf_response(input in_req_t req, input logic [7:0] poly);
    out_rsp_t rsp;
    rsp = '0;
    case (req.opcode)
      OPC_MUL: rsp.result = field_product(req.operand_a, req.operand_b, poly);
      OPC_POW: rsp.result = field_power(req.operand_a, req.operand_b, poly);
      OPC_INV: begin
        if (req.operand_a == 0) rsp.error = 1'b1;
        else rsp.result = field_inverse(req.operand_a, poly);
      end
      default: rsp = '0;
    endcase
    return rsp;
  endfunction

  task automatic push_req(input logic [OP_W-1:0] op, input logic [7:0] a, input logic [7:0] b);
    in_req_t req;
    req.opcode = op;
    req.operand_a = a;
    req.operand_b = b;
    req_q.push_back(req);
  endtask

  // Operands lean toward the corner values now and then.
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hFF;
      3: return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_random_req();
    logic [OP_W-1:0] op;
    if ($urandom_range(15) == 0) op = OPC_UNUSED;
    else op = OP_W'($urandom_range(2));
    push_req(op, pick_operand(), pick_operand());
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid || expected_rsp_q.size() != 0) @(negedge clk);
  endtask

  // The polynomial register is written only while nothing is in flight.
  task automatic write_poly(input logic [7:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    poly_model = value;
  endtask

  // Driver: offer the next request once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_rsp_q.push_back(gf_response(in_data, poly_model));
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= req_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted response and choose the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          if (error_count < MAX_REPORTS) $error("response with no request pending");
          error_count++;
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (out_data.result !== want_rsp.result) begin
            if (error_count < MAX_REPORTS)
              $error("result: expected %0h, got %0h", want_rsp.result, out_data.result);
            error_count++;
          end
          if (out_data.error !== want_rsp.error) begin
            if (error_count < MAX_REPORTS)
              $error("error: expected %0b, got %0b", want_rsp.error, out_data.error);
            error_count++;
          end
        end
      end
      if (holdoff_trigger && !holdoff_seen) begin
        holdoff_seen = 1'b1;
        holdoff_cnt = HOLDOFF_CYCLES;
      end
      if (holdoff_cnt > 0) begin
        holdoff_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("galois_field_arithmetic_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // Stimulus: directed corners, then phases over polynomials and idling patterns.
  initial begin
    logic [7:0] poly_list [NUM_PHASES];
    poly_list[0] = POLY_RESET;
    poly_list[1] = 8'h00;
    poly_list[2] = 8'hFF;
    poly_list[3] = 8'h1B;
    poly_list[4] = 8'($urandom_range(255));
    poly_list[5] = 8'($urandom_range(255));
    poly_list[6] = POLY_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Corners under the reset polynomial.
    push_req(OPC_MUL, 8'h00, 8'h00);
    push_req(OPC_MUL, 8'hFF, 8'hFF);
    push_req(OPC_MUL, 8'h01, 8'hAB);
    push_req(OPC_MUL, 8'h80, 8'h02);
    push_req(OPC_MUL, 8'hAA, 8'h55);
    push_req(OPC_POW, 8'h00, 8'h00);
    push_req(OPC_POW, 8'h53, 8'h00);
    push_req(OPC_POW, 8'h00, 8'h05);
    push_req(OPC_POW, 8'hFF, 8'hFF);
    push_req(OPC_POW, 8'h02, 8'hFF);
    push_req(OPC_POW, 8'h03, 8'h80);
    push_req(OPC_INV, 8'h00, 8'hFF);
    push_req(OPC_INV, 8'h01, 8'h00);
    push_req(OPC_INV, 8'hFF, 8'h00);
    push_req(OPC_INV, 8'h80, 8'h5A);
    push_req(OPC_INV, 8'h02, 8'hFF);
    push_req(OPC_UNUSED, 8'hFF, 8'hFF);
    push_req(OPC_UNUSED, 8'h00, 8'h00);

    for (int k = 0; k < NUM_PHASES; k++) begin
      if (k > 0) write_poly(poly_list[k]);
      @(negedge clk);
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (k == 2) begin
        // The receiver holds off while the sender keeps offering.
        for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) push_random_req();
        holdoff_trigger = 1'b1;
        for (int i = RANDOM_PER_PHASE / 2; i < RANDOM_PER_PHASE; i++) push_random_req();
      end else if (k == 3) begin
        // The sender pauses after each burst until every response is back.
        for (int i = 0; i < RANDOM_PER_PHASE; i += BURST_LEN) begin
          for (int j = 0; j < BURST_LEN; j++) push_random_req();
          wait_idle();
        end
      end else begin
        for (int i = 0; i < RANDOM_PER_PHASE; i++) push_random_req();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsp_q.size() == 0) begin
      $display("galois_field_arithmetic_unit_tb OK");
    end else begin
      $display("galois_field_arithmetic_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: galois_field_arithmetic_unit.f
+incdir+rtl
rtl/gfau_pkg.sv
rtl/gfau_mul.sv
rtl/galois_field_arithmetic_unit.sv
test/galois_field_arithmetic_unit_tb.sv
